FILE: design/mstp_pkg.sv
// Package for the melody sine tone player: request types, command codes and constant tables.
`timescale 1ns / 1ps
`default_nettype none

package mstp_pkg;

  localparam int unsigned SineLen   = 45;
  localparam int unsigned PosW      = 6;
  localparam int unsigned DacW      = 10;
  localparam int unsigned PeriodW   = 12;
  localparam int unsigned KindW     = 3;
  localparam int unsigned NoteW     = 3;
  localparam int unsigned NumMelody = 4;
  localparam int unsigned ProdW     = 20;
  localparam int unsigned RecipW    = 21;
  localparam int unsigned RecipShift = 30;

  localparam logic [DacW-1:0]   VolumeReset = 10'd819;
  localparam logic [DacW-1:0]   DacMax      = 10'd1023;
  // ceil(2^30 / 819); exact floor quotient for every product below 1422175
  localparam logic [RecipW-1:0] RecipMul    = 21'd1311041;
  // product of sine entry 0 and the reset gain
  localparam logic [ProdW-1:0]  ProdReset   = 20'd335790;

  localparam logic [PosW-1:0]   PosLast     = 6'(SineLen - 1);

  typedef enum logic [1:0] {
    CmdStart  = 2'd0,
    CmdNote   = 2'd1,
    CmdSample = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KindW-1:0] melody_kind;
  } mstp_req_t;

  typedef struct packed {
    logic [DacW-1:0]    dac_code;
    logic [PeriodW-1:0] note_period;
    logic               playing;
  } mstp_rsp_t;

  function automatic logic [DacW-1:0] sine_value(input logic [PosW-1:0] idx);
    logic [DacW-1:0] v;
    case (idx)
      6'd0:  v = 10'd410;  6'd1:  v = 10'd467;  6'd2:  v = 10'd523;
      6'd3:  v = 10'd576;  6'd4:  v = 10'd627;  6'd5:  v = 10'd673;
      6'd6:  v = 10'd714;  6'd7:  v = 10'd749;  6'd8:  v = 10'd778;
      6'd9:  v = 10'd799;  6'd10: v = 10'd813;  6'd11: v = 10'd819;
      6'd12: v = 10'd817;  6'd13: v = 10'd807;  6'd14: v = 10'd789;
      6'd15: v = 10'd764;  6'd16: v = 10'd732;  6'd17: v = 10'd694;
      6'd18: v = 10'd650;  6'd19: v = 10'd602;  6'd20: v = 10'd550;
      6'd21: v = 10'd495;  6'd22: v = 10'd438;  6'd23: v = 10'd381;
      6'd24: v = 10'd324;  6'd25: v = 10'd270;  6'd26: v = 10'd217;
      6'd27: v = 10'd169;  6'd28: v = 10'd125;  6'd29: v = 10'd87;
      6'd30: v = 10'd55;   6'd31: v = 10'd30;   6'd32: v = 10'd12;
      6'd33: v = 10'd2;    6'd34: v = 10'd0;    6'd35: v = 10'd6;
      6'd36: v = 10'd20;   6'd37: v = 10'd41;   6'd38: v = 10'd70;
      6'd39: v = 10'd105;  6'd40: v = 10'd146;  6'd41: v = 10'd193;
      6'd42: v = 10'd243;  6'd43: v = 10'd297;  6'd44: v = 10'd353;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  function automatic logic [PeriodW-1:0] period_value(input logic [NoteW-1:0] note);
    logic [PeriodW-1:0] v;
    case (note)
      3'd0: v = 12'd2120;
      3'd1: v = 12'd1890;
      3'd2: v = 12'd1684;
      3'd3: v = 12'd1592;
      3'd4: v = 12'd1417;
      3'd5: v = 12'd1263;
      3'd6: v = 12'd1125;
      default: v = 12'd1062;
    endcase
    return v;
  endfunction

  function automatic logic [NoteW:0] melody_len(input logic [1:0] m);
    logic [NoteW:0] v;
    case (m)
      2'd0: v = 4'd1;
      2'd1: v = 4'd3;
      2'd2: v = 4'd5;
      default: v = 4'd8;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/melody_sine_tone_player.sv
// Melody sine tone player: melody sequencing, sine stepping and DAC scaling in one pass.
// The response to an accepted request is registered and is presented from the cycle after acceptance.
// Throughput: one request per cycle; only a held response with out_stall_i high blocks input.
// The sample scale uses a registered product of sine entry and gain, computed from the next state, so
// the divide by 819 (a reciprocal multiply) starts from a register rather than from the sine table.
// Reset (rst_ni low, asynchronous): nothing playing, counters and sine phase at 0, gain 819.
`timescale 1ns / 1ps
`default_nettype none

module melody_sine_tone_player (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire mstp_pkg::mstp_req_t         in_req_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output mstp_pkg::mstp_rsp_t              out_req_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [mstp_pkg::DacW-1:0]   cfg_wdata_i
);

  // Player state
  logic [mstp_pkg::DacW-1:0]    gain_q, gain_d;
  logic [mstp_pkg::KindW-1:0]   active_q, active_d;
  logic [mstp_pkg::NoteW-1:0]   count_q [mstp_pkg::NumMelody];
  logic [mstp_pkg::NoteW-1:0]   count_d [mstp_pkg::NumMelody];
  logic [mstp_pkg::NoteW-1:0]   note_q, note_d;
  logic [mstp_pkg::PosW-1:0]    pos_q, pos_d;
  logic [mstp_pkg::DacW-1:0]    sample_q, sample_d;
  // sine_value(pos_q) * gain_q, kept in step with the state
  logic [mstp_pkg::ProdW-1:0]   prod_q, prod_d;

  // Output register
  logic                         out_valid_q;
  mstp_pkg::mstp_rsp_t          out_q, out_d;

  logic                         accept;
  logic [1:0]                   mel_idx;
  logic [mstp_pkg::NoteW:0]     next_count;
  logic [mstp_pkg::PosW-1:0]    pos_cur;
  logic [mstp_pkg::ProdW+mstp_pkg::RecipW-1:0] quot_full;
  logic [mstp_pkg::DacW:0]      quot;
  logic [mstp_pkg::DacW-1:0]    scaled;
  logic [mstp_pkg::KindW-1:0]   kind;

  // Take a request whenever the output register is empty or being drained.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  assign kind    = in_req_i.melody_kind;
  assign mel_idx = 2'(active_q - 3'd1);
  assign next_count = {1'b0, count_q[mel_idx]} + 4'd1;

  // Divide the registered product by 819 through the reciprocal; clamp to full scale.
  assign quot_full = prod_q * mstp_pkg::RecipMul;
  assign quot      = quot_full[mstp_pkg::ProdW+mstp_pkg::RecipW-1:mstp_pkg::RecipShift];
  assign scaled    = (quot > {1'b0, mstp_pkg::DacMax}) ? mstp_pkg::DacMax
                                                       : quot[mstp_pkg::DacW-1:0];

  // Out-of-range phase restarts the table.
  assign pos_cur = (pos_q > mstp_pkg::PosLast) ? '0 : pos_q;

  always_comb begin
    gain_d   = cfg_we_i ? cfg_wdata_i : gain_q;
    active_d = active_q;
    count_d  = count_q;
    note_d   = note_q;
    pos_d    = pos_q;
    sample_d = sample_q;

    if (accept) begin
      unique case (mstp_pkg::cmd_e'(in_req_i.cmd))
        mstp_pkg::CmdStart: begin
          // Ignore unknown melody kinds; the old melody's counter stays as it is.
          if (kind >= 3'd1 && kind <= 3'd4) begin
            active_d = kind;
            note_d   = '0;
          end
        end
        mstp_pkg::CmdNote: begin
          if (active_q >= 3'd1 && active_q <= 3'd4) begin
            if (next_count >= mstp_pkg::melody_len(mel_idx)) begin
              // Melody done: clear its counter, keep the last note for the period.
              count_d[mel_idx] = '0;
              active_d         = '0;
            end else begin
              count_d[mel_idx] = next_count[mstp_pkg::NoteW-1:0];
              note_d           = next_count[mstp_pkg::NoteW-1:0];
            end
          end
        end
        mstp_pkg::CmdSample: begin
          if (active_q != '0) begin
            sample_d = scaled;
            pos_d    = (pos_cur == mstp_pkg::PosLast) ? '0 : pos_cur + 6'd1;
          end
        end
        default: begin
        end
      endcase
    end

    prod_d = {{(mstp_pkg::ProdW-mstp_pkg::DacW){1'b0}},
              mstp_pkg::sine_value((pos_d > mstp_pkg::PosLast) ? '0 : pos_d)} *
             {{(mstp_pkg::ProdW-mstp_pkg::DacW){1'b0}}, gain_d};

    out_d.dac_code    = sample_d;
    out_d.note_period = mstp_pkg::period_value(note_d);
    out_d.playing     = (active_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= mstp_pkg::VolumeReset;
      active_q    <= '0;
      count_q     <= '{default: '0};
      note_q      <= '0;
      pos_q       <= '0;
      sample_q    <= '0;
      prod_q      <= mstp_pkg::ProdReset;
      out_valid_q <= 1'b0;
    end else begin
      gain_q   <= gain_d;
      active_q <= active_d;
      count_q  <= count_d;
      note_q   <= note_d;
      pos_q    <= pos_d;
      sample_q <= sample_d;
      prod_q   <= prod_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Response payload: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Testbench for the melody sine tone player: directed and random requests checked against a model.
`timescale 1ns / 1ps

module testbench;

  // Melody kinds as carried in melody_kind; zero and the top codes are rejected by the block.
  localparam logic [mstp_pkg::KindW-1:0] KindNone   = 3'd0;
  localparam logic [mstp_pkg::KindW-1:0] KindClick  = 3'd1;
  localparam logic [mstp_pkg::KindW-1:0] KindEat    = 3'd2;
  localparam logic [mstp_pkg::KindW-1:0] KindDeath  = 3'd3;
  localparam logic [mstp_pkg::KindW-1:0] KindCuddle = 3'd4;
  localparam logic [mstp_pkg::KindW-1:0] KindTop    = 3'd7;

  localparam int unsigned FullScale     = 819;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHold      = 300;

  // One period of the sine, the note period table and the melody lengths, index 0 leftmost.
  localparam logic [0:44][mstp_pkg::DacW-1:0] SineSteps = {
    10'd410, 10'd467, 10'd523, 10'd576, 10'd627, 10'd673, 10'd714, 10'd749, 10'd778,
    10'd799, 10'd813, 10'd819, 10'd817, 10'd807, 10'd789, 10'd764, 10'd732, 10'd694,
    10'd650, 10'd602, 10'd550, 10'd495, 10'd438, 10'd381, 10'd324, 10'd270, 10'd217,
    10'd169, 10'd125, 10'd87,  10'd55,  10'd30,  10'd12,  10'd2,   10'd0,   10'd6,
    10'd20,  10'd41,  10'd70,  10'd105, 10'd146, 10'd193, 10'd243, 10'd297, 10'd353
  };
  localparam logic [0:7][mstp_pkg::PeriodW-1:0] NotePeriods = {
    12'd2120, 12'd1890, 12'd1684, 12'd1592, 12'd1417, 12'd1263, 12'd1125, 12'd1062
  };
  localparam logic [0:3][3:0] MelodyNotes = {4'd1, 4'd3, 4'd5, 4'd8};

  // Block inputs start at known values; the sender and receiver processes own them after that.
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  mstp_pkg::mstp_req_t          in_req_i    = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  mstp_pkg::mstp_rsp_t          out_req_o;
  logic                         cfg_we_i    = 1'b0;
  logic [mstp_pkg::DacW-1:0]    cfg_wdata_i = '0;

  // Player model state, updated at the edge where a request is accepted.
  logic [mstp_pkg::DacW-1:0]    tone_gain;
  logic [mstp_pkg::KindW-1:0]   tone_melody;
  logic [3:0]                   tone_counts [4];
  logic [mstp_pkg::NoteW-1:0]   tone_note;
  logic [mstp_pkg::PosW-1:0]    tone_phase;
  logic [mstp_pkg::DacW-1:0]    tone_sample;

  mstp_pkg::mstp_rsp_t          pending_tones [$];
  int unsigned                  mismatches     = 0;
  int unsigned                  send_idle_pct  = 0;
  int unsigned                  recv_stall_pct = 0;
  int unsigned                  hold_request   = 0;
  int unsigned                  hold_left      = 0;
  int unsigned                  quiet_cycles   = 0;

  melody_sine_tone_player i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Player model
  // ---------------------------------------------------------------------------

  task automatic reset_player();
    tone_gain   = mstp_pkg::VolumeReset;
    tone_melody = KindNone;
    for (int m = 0; m < 4; m++) tone_counts[m] = '0;
    tone_note   = '0;
    tone_phase  = '0;
    tone_sample = '0;
  endtask

  // Apply one request to the model and return the response it must produce.
  function automatic mstp_pkg::mstp_rsp_t play_step(input mstp_pkg::mstp_req_t req);
    mstp_pkg::mstp_rsp_t rsp;
    int unsigned slot;
    int unsigned next_note;
    int unsigned pos;
    int unsigned level;
    case (mstp_pkg::cmd_e'(req.cmd))
      mstp_pkg::CmdStart: begin
        // Reject kinds outside click..cuddle; keep the sine phase on a valid start.
        if (req.melody_kind >= KindClick && req.melody_kind <= KindCuddle) begin
          tone_melody = req.melody_kind;
          tone_note   = '0;
        end
      end
      mstp_pkg::CmdNote: begin
        // Advance the active melody's own counter; clear it only when the melody ends.
        if (tone_melody != KindNone) begin
          slot      = tone_melody - 1;
          next_note = tone_counts[slot] + 1;
          if (next_note >= MelodyNotes[slot]) begin
            tone_counts[slot] = '0;
            tone_melody       = KindNone;
          end else begin
            tone_counts[slot] = 4'(next_note);
            tone_note         = mstp_pkg::NoteW'(next_note);
          end
        end
      end
      mstp_pkg::CmdSample: begin
        // Scale the current sine step by the gain, saturate, then step with wrap.
        if (tone_melody != KindNone) begin
          pos = tone_phase;
          if (pos >= mstp_pkg::SineLen) pos = 0;
          level = (int'(SineSteps[pos]) * int'(tone_gain)) / FullScale;
          if (level > mstp_pkg::DacMax) level = mstp_pkg::DacMax;
          tone_sample = mstp_pkg::DacW'(level);
          pos++;
          if (pos >= mstp_pkg::SineLen) pos = 0;
          tone_phase = mstp_pkg::PosW'(pos);
        end
      end
      default: ;
    endcase
    rsp.dac_code    = tone_sample;
    rsp.note_period = NotePeriods[tone_note];
    rsp.playing     = (tone_melody != KindNone);
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check responses in order, track gain writes, predict each request
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    mstp_pkg::mstp_rsp_t want;
    if (rst_ni) begin
      // Pop before push: a response never belongs to the request taken at the same edge.
      if (out_valid_o && !out_stall_i) begin
        if (pending_tones.size() == 0) begin
          $display("%0t: response with no request pending, expected none actual %p",
                   $time, out_req_o);
          mismatches++;
        end else begin
          want = pending_tones.pop_front();
          check_field("dac_code", want.dac_code, out_req_o.dac_code);
          check_field("note_period", want.note_period, out_req_o.note_period);
          check_field("playing", want.playing, out_req_o.playing);
        end
      end
      if (cfg_we_i) tone_gain = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) pending_tones.push_back(play_step(in_req_i));
    end
  end

  // Receiver: stall at random, or hold off for a requested stretch counted here.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: timeout, no request moved for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at the current rate; hold it until taken.
  task automatic send_item(input mstp_pkg::cmd_e cmd,
                           input logic [mstp_pkg::KindW-1:0] kind);
    mstp_pkg::mstp_req_t req;
    req.cmd         = cmd;
    req.melody_kind = kind;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted response is back, plus the latency.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_tones.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the gain only with the block idle.
  task automatic set_volume(input logic [mstp_pkg::DacW-1:0] gain);
    wait_all_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= gain;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [mstp_pkg::KindW-1:0] any_kind();
    return mstp_pkg::KindW'($urandom);
  endfunction

  // Mostly well-formed plays (start, then a run of ticks); the rest is raw noise.
  task automatic send_random_items(input int count);
    int sent;
    int run;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 75) begin
        send_item(mstp_pkg::CmdStart,
                  mstp_pkg::KindW'($urandom_range(KindClick, KindCuddle)));
        run = $urandom_range(1, 12);
        repeat (run) begin
          if ($urandom_range(99) < 65) send_item(mstp_pkg::CmdSample, any_kind());
          else send_item(mstp_pkg::CmdNote, any_kind());
        end
        sent += run + 1;
      end else begin
        send_item(mstp_pkg::cmd_e'($urandom_range(0, 3)), any_kind());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle behavior, rejected kinds, every melody, replace-while-playing and counter resume.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(mstp_pkg::CmdSample, KindNone);     // idle sample tick holds a zero code
    send_item(mstp_pkg::CmdNote, KindTop);        // idle note tick changes nothing
    send_item(mstp_pkg::CmdNone, KindTop);        // unused command still answers
    send_item(mstp_pkg::CmdStart, KindNone);      // rejected kinds leave state alone
    send_item(mstp_pkg::CmdStart, KindTop);
    send_item(mstp_pkg::CmdStart, KindClick);
    send_item(mstp_pkg::CmdSample, KindNone);
    send_item(mstp_pkg::CmdNote, KindNone);       // one-note melody ends here
    send_item(mstp_pkg::CmdSample, KindNone);     // stopped: code and period hold
    send_item(mstp_pkg::CmdStart, KindEat);
    send_item(mstp_pkg::CmdNote, KindNone);
    send_item(mstp_pkg::CmdSample, KindNone);
    send_item(mstp_pkg::CmdStart, KindDeath);     // replace eat, keep its counter
    send_item(mstp_pkg::CmdNote, KindNone);
    send_item(mstp_pkg::CmdStart, KindEat);       // eat resumes from its kept count
    send_item(mstp_pkg::CmdNote, KindNone);
    send_item(mstp_pkg::CmdNote, KindNone);
    send_item(mstp_pkg::CmdStart, KindCuddle);
    repeat (8) send_item(mstp_pkg::CmdNote, KindNone);
    wait_all_results();
  endtask

  // Gain extremes and a small gain, each over a run of sample ticks.
  task automatic test_volume_extremes();
    logic [mstp_pkg::DacW-1:0] gains [3];
    gains = '{10'd0, mstp_pkg::DacMax, 10'd1};
    foreach (gains[g]) begin
      set_volume(gains[g]);
      send_item(mstp_pkg::CmdStart, KindDeath);
      repeat (15) send_item(mstp_pkg::CmdSample, any_kind());
    end
    wait_all_results();
  endtask

  // One random phase at a given gain and idle rates.
  task automatic test_random_phase(input logic [mstp_pkg::DacW-1:0] gain,
                                   input int unsigned send_pct,
                                   input int unsigned stall_pct, input int count);
    set_volume(gain);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    send_random_items(count);
    wait_all_results();
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, then pause fully.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_all_results();
    hold_request = LongHold;
    send_item(mstp_pkg::CmdStart, KindCuddle);
    send_random_items(30);
    wait_all_results();
    send_random_items(20);
    wait_all_results();
  endtask

  initial begin
    reset_player();
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_volume_extremes();
    test_random_phase(mstp_pkg::VolumeReset, 0, 0, 130);
    test_random_phase(mstp_pkg::DacMax, 80, 0, 130);
    test_random_phase(10'($urandom), 0, 80, 130);
    test_random_phase(10'($urandom), 37, 37, 130);
    test_backpressure();

    wait_all_results();
    if (mismatches == 0 && pending_tones.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
